FILE: sv/scs_pkg.sv
// Shared types, constants and codes for the stepwise cocktail sort block.
package scs_pkg;

    localparam int ELEM_COUNT_DEF = 128;
    localparam int REQ_W          = 2;
    localparam int INDEX_W        = 7;
    localparam int VALUE_W        = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE   = 2'd0,
        REQ_STEP    = 2'd1,
        REQ_READ    = 2'd2,
        REQ_RESTART = 2'd3
    } req_type_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_SCAN_INIT,
        ST_SCAN_FIRST,
        ST_SCAN_CMP,
        ST_SWAP_LO,
        ST_SWAP_HI,
        ST_RESP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic req_write;      // store request value
        logic req_read;       // point read address at request index
        logic restart;        // position 0, forward
        logic scan_begin;     // first scan from kept position and direction
        logic scan_fallback;  // full scan in the opposite direction
        logic scan_advance;   // shift prev, step index and read address
        logic hit_capture;    // latch swap pair, update position
        logic swap_lo;        // write lower element of the pair
        logic swap_hi;        // write upper element of the pair
        logic res_zero;       // clear result fields
        logic res_read;       // take read data as result
        logic res_done;       // flag no out-of-order pair
        logic out_load;       // move result into the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_empty;     // no pair between start and scan end
        logic scan_hit;       // current pair out of order
        logic scan_last;      // current element is the scan end
        logic scan_second;    // running the fallback scan
        logic out_free;       // output register can take a beat
    } status_t;

endpackage

FILE: sv/scs_in_if.sv
// Request channel: valid/ready handshake with request payload.
interface scs_in_if
    import scs_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [REQ_W-1:0]          req_type;
    logic [INDEX_W-1:0]        elem_index;
    logic signed [VALUE_W-1:0] elem_value;

    modport source (output valid, output req_type, output elem_index, output elem_value,
                    input ready);
    modport sink   (input valid, input req_type, input elem_index, input elem_value,
                    output ready);
endinterface

FILE: sv/scs_out_if.sv
// Result channel: valid/ready handshake with result payload.
interface scs_out_if
    import scs_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] read_value;
    logic                      swapped;
    logic [INDEX_W-1:0]        swap_low_index;
    logic                      done_res;

    modport source (output valid, output read_value, output swapped,
                    output swap_low_index, output done_res, input ready);
    modport sink   (input valid, input read_value, input swapped,
                    input swap_low_index, input done_res, output ready);
endinterface

FILE: sv/scs_ctrl.sv
// Sequencing state machine for requests, scans and swaps.
module scs_ctrl
    import scs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [REQ_W-1:0] req_type,
    input  status_t          sts,
    output logic             in_ready,
    output cmd_t             cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (req_type_t'(req_type))
                        REQ_WRITE:   state_next = ST_RESP;
                        REQ_STEP:    state_next = ST_SCAN_INIT;
                        REQ_READ:    state_next = ST_RD_ADDR;
                        REQ_RESTART: state_next = ST_RESP;
                        default:     state_next = ST_RESP;
                    endcase
                end
            end
            ST_RD_ADDR:    state_next = ST_RD_DATA;
            ST_RD_DATA:    state_next = ST_RESP;
            ST_SCAN_INIT:
            begin
                if (sts.scan_empty)
                begin
                    state_next = sts.scan_second ? ST_RESP : ST_SCAN_INIT;
                end
                else
                begin
                    state_next = ST_SCAN_FIRST;
                end
            end
            ST_SCAN_FIRST: state_next = ST_SCAN_CMP;
            ST_SCAN_CMP:
            begin
                if (sts.scan_hit)
                begin
                    state_next = ST_SWAP_LO;
                end
                else if (sts.scan_last)
                begin
                    state_next = sts.scan_second ? ST_RESP : ST_SCAN_INIT;
                end
            end
            ST_SWAP_LO:    state_next = ST_SWAP_HI;
            ST_SWAP_HI:    state_next = ST_RESP;
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.res_zero = 1'b1;
                    unique case (req_type_t'(req_type))
                        REQ_WRITE:   cmd.req_write  = 1'b1;
                        REQ_STEP:    cmd.scan_begin = 1'b1;
                        REQ_READ:    cmd.req_read   = 1'b1;
                        REQ_RESTART: cmd.restart    = 1'b1;
                        default:     cmd.res_zero   = 1'b1;
                    endcase
                end
            end
            ST_RD_ADDR:    cmd = '0;
            ST_RD_DATA:    cmd.res_read = 1'b1;
            ST_SCAN_INIT:
            begin
                if (sts.scan_empty)
                begin
                    if (sts.scan_second)
                    begin
                        cmd.res_done = 1'b1;
                    end
                    else
                    begin
                        cmd.scan_fallback = 1'b1;
                    end
                end
                else
                begin
                    cmd.scan_advance = 1'b1;
                end
            end
            ST_SCAN_FIRST: cmd.scan_advance = 1'b1;
            ST_SCAN_CMP:
            begin
                if (sts.scan_hit)
                begin
                    cmd.hit_capture = 1'b1;
                end
                else if (sts.scan_last)
                begin
                    if (sts.scan_second)
                    begin
                        cmd.res_done = 1'b1;
                    end
                    else
                    begin
                        cmd.scan_fallback = 1'b1;
                    end
                end
                else
                begin
                    cmd.scan_advance = 1'b1;
                end
            end
            ST_SWAP_LO:    cmd.swap_lo = 1'b1;
            ST_SWAP_HI:    cmd.swap_hi = 1'b1;
            ST_RESP:       cmd.out_load = sts.out_free;
            default:       cmd = '0;
        endcase
    end

endmodule

FILE: sv/scs_datapath.sv
// Element memory, scan pointers, pair compare and result/output registers.
module scs_datapath
    import scs_pkg::*;
#(
    parameter int ELEM_COUNT = ELEM_COUNT_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cmd_t                      cmd,
    output status_t                   sts,
    input  logic [INDEX_W-1:0]        elem_index,
    input  logic signed [VALUE_W-1:0] elem_value,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic signed [VALUE_W-1:0] read_value,
    output logic                      swapped,
    output logic [INDEX_W-1:0]        swap_low_index,
    output logic                      done_res
);

    localparam int AW = (ELEM_COUNT > 1) ? $clog2(ELEM_COUNT) : 1;
    localparam logic [AW-1:0] LAST = AW'(ELEM_COUNT - 1);

    logic signed [VALUE_W-1:0] mem [ELEM_COUNT];
    logic signed [VALUE_W-1:0] rdata_reg;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic signed [VALUE_W-1:0] mem_wd;

    // control registers
    logic          dir_reg,    dir_next;
    logic          second_reg, second_next;
    logic [AW-1:0] pos_reg,    pos_next;
    logic          fwd_reg,    fwd_next;
    logic          out_valid_reg, out_valid_next;

    // payload registers
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] idx_reg,  idx_next;
    logic signed [VALUE_W-1:0] prev_reg, prev_next;
    logic          rd_ok_reg, rd_ok_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic signed [VALUE_W-1:0] lo_val_reg, lo_val_next;
    logic signed [VALUE_W-1:0] hi_val_reg, hi_val_next;
    logic signed [VALUE_W-1:0] res_value_reg, res_value_next;
    logic          res_swapped_reg, res_swapped_next;
    logic [INDEX_W-1:0] res_low_reg, res_low_next;
    logic          res_done_reg, res_done_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic          out_swapped_reg, out_swapped_next;
    logic [INDEX_W-1:0] out_low_reg, out_low_next;
    logic          out_done_reg, out_done_next;

    logic          idx_ok;
    logic          hit;
    logic [AW-1:0] lo_idx;
    logic [AW-1:0] addr_step;

    assign idx_ok = (32'(elem_index) < ELEM_COUNT);
    assign hit    = dir_reg ? (prev_reg > rdata_reg) : (prev_reg < rdata_reg);
    assign lo_idx = dir_reg ? (idx_reg - AW'(1)) : idx_reg;

    // step toward the scan end, holding there
    always_comb
    begin
        if (dir_reg)
        begin
            addr_step = (addr_reg == LAST) ? addr_reg : addr_reg + AW'(1);
        end
        else
        begin
            addr_step = (addr_reg == '0) ? addr_reg : addr_reg - AW'(1);
        end
    end

    assign sts.scan_empty  = dir_reg ? (addr_reg == LAST) : (addr_reg == '0);
    assign sts.scan_hit    = hit;
    assign sts.scan_last   = dir_reg ? (idx_reg == LAST) : (idx_reg == '0);
    assign sts.scan_second = second_reg;
    assign sts.out_free    = !out_valid_reg || out_ready;

    // memory write select
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = lo_reg;
        mem_wd = lo_val_reg;
        if (cmd.req_write && idx_ok)
        begin
            mem_we = 1'b1;
            mem_wa = AW'(elem_index);
            mem_wd = elem_value;
        end
        else if (cmd.swap_lo)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.swap_hi)
        begin
            mem_we = 1'b1;
            mem_wa = lo_reg + AW'(1);
            mem_wd = hi_val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[addr_reg];
    end

    always_comb
    begin
        dir_next         = dir_reg;
        second_next      = second_reg;
        pos_next         = pos_reg;
        fwd_next         = fwd_reg;
        out_valid_next   = out_valid_reg;
        addr_next        = addr_reg;
        idx_next         = idx_reg;
        prev_next        = prev_reg;
        rd_ok_next       = rd_ok_reg;
        lo_next          = lo_reg;
        lo_val_next      = lo_val_reg;
        hi_val_next      = hi_val_reg;
        res_value_next   = res_value_reg;
        res_swapped_next = res_swapped_reg;
        res_low_next     = res_low_reg;
        res_done_next    = res_done_reg;
        out_value_next   = out_value_reg;
        out_swapped_next = out_swapped_reg;
        out_low_next     = out_low_reg;
        out_done_next    = out_done_reg;

        if (cmd.res_zero)
        begin
            res_value_next   = '0;
            res_swapped_next = 1'b0;
            res_low_next     = '0;
            res_done_next    = 1'b0;
        end
        if (cmd.req_read)
        begin
            rd_ok_next = idx_ok;
            if (idx_ok)
            begin
                addr_next = AW'(elem_index);
            end
        end
        if (cmd.restart)
        begin
            pos_next = '0;
            fwd_next = 1'b1;
        end
        if (cmd.scan_begin)
        begin
            dir_next    = fwd_reg;
            second_next = 1'b0;
            addr_next   = pos_reg;
        end
        if (cmd.scan_fallback)
        begin
            dir_next    = !dir_reg;
            second_next = 1'b1;
            addr_next   = dir_reg ? LAST : '0;
        end
        if (cmd.scan_advance)
        begin
            prev_next = rdata_reg;
            idx_next  = addr_reg;
            addr_next = addr_step;
        end
        if (cmd.hit_capture)
        begin
            lo_next          = lo_idx;
            lo_val_next      = dir_reg ? rdata_reg : prev_reg;
            hi_val_next      = dir_reg ? prev_reg : rdata_reg;
            pos_next         = idx_reg;
            fwd_next         = dir_reg;
            res_swapped_next = 1'b1;
            res_low_next     = INDEX_W'(lo_idx);
        end
        if (cmd.res_read)
        begin
            res_value_next = rd_ok_reg ? rdata_reg : '0;
        end
        if (cmd.res_done)
        begin
            res_done_next = 1'b1;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next   = 1'b1;
            out_value_next   = res_value_reg;
            out_swapped_next = res_swapped_reg;
            out_low_next     = res_low_reg;
            out_done_next    = res_done_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg       <= 1'b1;
            second_reg    <= 1'b0;
            pos_reg       <= '0;
            fwd_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dir_reg       <= dir_next;
            second_reg    <= second_next;
            pos_reg       <= pos_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg        <= addr_next;
        idx_reg         <= idx_next;
        prev_reg        <= prev_next;
        rd_ok_reg       <= rd_ok_next;
        lo_reg          <= lo_next;
        lo_val_reg      <= lo_val_next;
        hi_val_reg      <= hi_val_next;
        res_value_reg   <= res_value_next;
        res_swapped_reg <= res_swapped_next;
        res_low_reg     <= res_low_next;
        res_done_reg    <= res_done_next;
        out_value_reg   <= out_value_next;
        out_swapped_reg <= out_swapped_next;
        out_low_reg     <= out_low_next;
        out_done_reg    <= out_done_next;
    end

    assign out_valid      = out_valid_reg;
    assign read_value     = out_value_reg;
    assign swapped        = out_swapped_reg;
    assign swap_low_index = out_low_reg;
    assign done_res       = out_done_reg;

endmodule

FILE: sv/stepwise_cocktail_sort.sv
// Top level of the stepwise cocktail sort block.
//
// Holds ELEM_COUNT signed 16-bit elements in a single-port-write RAM and sorts
// them ascending by cocktail shaker sort, one swap per step request. Every
// request beat produces exactly one result beat. A step streams the RAM
// through its one read port and compares one adjacent pair per cycle from the
// kept position in the kept direction; on the first out-of-order pair it
// writes the swapped pair back, lower element then upper (one write port). If
// the kept direction is clean the whole array is scanned the other way.
// One request is worked on at a time; a finished result sits in the output
// register while the next request beat is accepted. Elements must be written
// before a step or read touches them; there is no clearing pass after reset.
// Writes and reads with elem_index >= ELEM_COUNT are ignored / read as zero.
module stepwise_cocktail_sort
    import scs_pkg::*;
#(
    parameter int ELEM_COUNT = ELEM_COUNT_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    scs_in_if.sink    request,
    scs_out_if.source result
);

    cmd_t    cmd;
    status_t sts;
    logic    in_ready;

    // request sequencing: idle/accept, read wait, scan, swap, respond
    scs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .req_type (request.req_type),
        .sts      (sts),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // element RAM, scan pointers, compare and output register
    scs_datapath #(
        .ELEM_COUNT (ELEM_COUNT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .elem_index     (request.elem_index),
        .elem_value     (request.elem_value),
        .out_ready      (result.ready),
        .out_valid      (result.valid),
        .read_value     (result.read_value),
        .swapped        (result.swapped),
        .swap_low_index (result.swap_low_index),
        .done_res       (result.done_res)
    );

    // ready only in idle; the output register decouples the result side
    assign request.ready = in_ready;

endmodule

FILE: sv/scs_checker.sv
// Port-level assertions for the stepwise cocktail sort block, with bind.
module scs_checker
    import scs_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [VALUE_W-1:0] read_value,
    input logic                      swapped,
    input logic [INDEX_W-1:0]        swap_low_index,
    input logic                      done_res
);

    // a stalled result beat stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // one request at a time: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while previous one in progress");

    // a step either swaps or reports done, never both
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(swapped && done_res))
        else $error("swap and done flagged together");

    // read data and swap index only appear on their own request kinds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_value != '0) |-> !swapped && !done_res &&
            (swap_low_index == '0))
        else $error("read result carries step fields");

endmodule

bind stepwise_cocktail_sort scs_checker u_scs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (request.valid),
    .in_ready       (request.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .read_value     (result.read_value),
    .swapped        (result.swapped),
    .swap_low_index (result.swap_low_index),
    .done_res       (result.done_res)
);

FILE: tb/sv/stepwise_cocktail_sort_scoreboard.sv
// Scoreboard for the stepwise cocktail sort: shadow array, result prediction and compare.
module stepwise_cocktail_sort_scoreboard
    import scs_pkg::*;
#(
    parameter int ELEM_COUNT = ELEM_COUNT_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    scs_in_if    req_ch,
    scs_out_if   res_ch,
    output int   fail_count,
    output int   pending_count,
    output int   write_count,
    output int   read_count,
    output int   restart_count,
    output int   step_count,
    output int   swap_count,
    output int   done_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic                      swapped;
        logic [INDEX_W-1:0]        swap_low_index;
        logic                      done_res;
    } sort_result_t;

    logic signed [VALUE_W-1:0] shadow_elems [ELEM_COUNT];
    int unsigned               scan_pos;
    bit                        scan_fwd;
    sort_result_t              expected_results [$];

    function automatic void swap_pair_at(int unsigned lo);
        logic signed [VALUE_W-1:0] tmp;
        tmp                  = shadow_elems[lo];
        shadow_elems[lo]     = shadow_elems[lo + 1];
        shadow_elems[lo + 1] = tmp;
    endfunction

    // first pair (i, i+1) out of order at or after start; leaves position at i+1
    function automatic bit scan_upward(int unsigned start, output int unsigned lo);
        lo = 0;
        for (int unsigned i = start; i + 1 < ELEM_COUNT; i++)
        begin
            if (shadow_elems[i] > shadow_elems[i + 1])
            begin
                swap_pair_at(i);
                scan_pos = i + 1;
                scan_fwd = 1'b1;
                lo       = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // first pair (i-1, i) out of order at or below start; leaves position at i-1
    function automatic bit scan_downward(int unsigned start, output int unsigned lo);
        lo = 0;
        for (int i = start; i > 0; i--)
        begin
            if (shadow_elems[i] < shadow_elems[i - 1])
            begin
                swap_pair_at(i - 1);
                scan_pos = i - 1;
                scan_fwd = 1'b0;
                lo       = i - 1;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic sort_result_t predict_request(req_type_t kind,
                                                     logic [INDEX_W-1:0] idx,
                                                     logic signed [VALUE_W-1:0] val);
        sort_result_t res;
        int unsigned  lo;
        bit           hit;
        res = '0;
        lo  = 0;
        hit = 1'b0;
        case (kind)
            REQ_WRITE:
            begin
                write_count++;
                if (idx < ELEM_COUNT)
                    shadow_elems[idx] = val;
            end
            REQ_STEP:
            begin
                step_count++;
                if (scan_fwd)
                begin
                    hit = scan_upward(scan_pos, lo);
                    if (!hit)
                        hit = scan_downward(ELEM_COUNT - 1, lo);
                end
                else
                begin
                    hit = scan_downward(scan_pos, lo);
                    if (!hit)
                        hit = scan_upward(0, lo);
                end
                if (hit)
                begin
                    res.swapped        = 1'b1;
                    res.swap_low_index = lo[INDEX_W-1:0];
                    swap_count++;
                end
                else
                begin
                    res.done_res = 1'b1;
                    done_count++;
                end
            end
            REQ_READ:
            begin
                read_count++;
                if (idx < ELEM_COUNT)
                    res.read_value = shadow_elems[idx];
            end
            default:
            begin
                restart_count++;
                scan_pos = 0;
                scan_fwd = 1'b1;
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_beats
        sort_result_t seen;
        sort_result_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            scan_pos      = 0;
            scan_fwd      = 1'b1;
            fail_count    = 0;
            pending_count = 0;
            write_count   = 0;
            read_count    = 0;
            restart_count = 0;
            step_count    = 0;
            swap_count    = 0;
            done_count    = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                expected_results.push_back(predict_request(req_type_t'(req_ch.req_type),
                                                           req_ch.elem_index,
                                                           req_ch.elem_value));
            if (res_ch.valid && res_ch.ready)
            begin
                seen.read_value     = res_ch.read_value;
                seen.swapped        = res_ch.swapped;
                seen.swap_low_index = res_ch.swap_low_index;
                seen.done_res       = res_ch.done_res;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat: read_value %0d swapped %0b low %0d done %0b",
                             $time, seen.read_value, seen.swapped, seen.swap_low_index,
                             seen.done_res);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (seen !== want)
                    begin
                        $display("%0t: result mismatch: expected read_value %0d swapped %0b low %0d done %0b",
                                 $time, want.read_value, want.swapped, want.swap_low_index,
                                 want.done_res);
                        $display("%0t:                    actual read_value %0d swapped %0b low %0d done %0b",
                                 $time, seen.read_value, seen.swapped, seen.swap_low_index,
                                 seen.done_res);
                        fail_count++;
                    end
                end
            end
            pending_count = expected_results.size();
        end
    end

endmodule

FILE: tb/sv/stepwise_cocktail_sort_tb.sv
// Testbench top for the stepwise cocktail sort: stimulus, idling, watchdog and verdict.
module stepwise_cocktail_sort_tb;
    import scs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ELEM_COUNT   = ELEM_COUNT_DEF;
    localparam int RANDOM_BEATS = 1800;
    // a step may scan the array both ways; allow that plus long receiver stalls
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 2 * ELEM_COUNT + 40;
    localparam int MIN_VALUE    = -32768;
    localparam int MAX_VALUE    = 32767;

    logic clk;
    logic rst_n;

    scs_in_if  request ();
    scs_out_if result ();

    int fail_count;
    int pending_count;
    int write_count;
    int read_count;
    int restart_count;
    int step_count;
    int swap_count;
    int done_count;

    // idle odds in percent, changed per phase of the random part
    int tx_idle_pct = 12;
    int rx_idle_pct = 48;

    int beats_sent = 0;
    // current ascending fill pattern: value(i) = fill_base + i * fill_step
    int fill_base  = 0;
    int fill_step  = 1;

    stepwise_cocktail_sort #(
        .ELEM_COUNT(ELEM_COUNT)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(request),
        .result (result)
    );

    stepwise_cocktail_sort_scoreboard #(
        .ELEM_COUNT(ELEM_COUNT)
    ) sort_board (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_ch       (request),
        .res_ch       (result),
        .fail_count   (fail_count),
        .pending_count(pending_count),
        .write_count  (write_count),
        .read_count   (read_count),
        .restart_count(restart_count),
        .step_count   (step_count),
        .swap_count   (swap_count),
        .done_count   (done_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver: ready drops at random with the current odds, low until the first edge.
    initial
    begin
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: any accepted beat on either channel clears the quiet count.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (request.valid && request.ready) || (result.valid && result.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("stepwise_cocktail_sort_tb failed");
        $finish;
    end

    function automatic int fill_value(int i);
        return fill_base + i * fill_step;
    endfunction

    // One request beat. Optional idle gap first; valid only ever gets one
    // assignment per time step, so back-to-back beats keep valid high.
    task automatic send_beat(req_type_t kind, int idx, int val);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            request.valid <= 1'b0;
            @(posedge clk);
        end
        request.valid      <= 1'b1;
        request.req_type   <= kind;
        request.elem_index <= idx[INDEX_W-1:0];
        request.elem_value <= val[VALUE_W-1:0];
        @(posedge clk);
        while (!request.ready)
            @(posedge clk);
        beats_sent++;
    endtask

    // Writes every element with a fresh ascending ramp, so nothing unwritten
    // is ever scanned. A step of 0 gives an array of equal values.
    task automatic refill_ramp(int min_step);
        int span;
        fill_step = $urandom_range(255, min_step);
        span      = 65535 - (ELEM_COUNT - 1) * fill_step;
        fill_base = MIN_VALUE + $urandom_range(span);
        for (int i = 0; i < ELEM_COUNT; i++)
            send_beat(REQ_WRITE, i, fill_value(i));
    endtask

    // Directed part on a strictly ascending ramp: done on a sorted array,
    // value and index extremes, all four scan transitions (forward hit,
    // forward miss then backward hit, backward hit, backward miss then
    // forward hit), restart taking precedence over the kept position, and
    // a done step leaving the state alone.
    task automatic directed_checks();
        send_beat(REQ_READ, 0, 0);
        send_beat(REQ_READ, ELEM_COUNT - 1, 0);
        send_beat(REQ_STEP, 0, 0);                        // already sorted: done
        send_beat(REQ_WRITE, 0, MIN_VALUE);
        send_beat(REQ_WRITE, ELEM_COUNT - 1, MAX_VALUE);
        send_beat(REQ_READ, 0, 0);
        send_beat(REQ_READ, ELEM_COUNT - 1, 0);
        send_beat(REQ_WRITE, 90, fill_value(88));
        send_beat(REQ_STEP, 0, 0);                        // forward hit at 89
        send_beat(REQ_WRITE, 20, fill_value(22));
        send_beat(REQ_STEP, 0, 0);                        // forward miss, backward hit at 20
        send_beat(REQ_WRITE, 10, fill_value(12));
        send_beat(REQ_STEP, 0, 0);                        // backward hit at 10
        send_beat(REQ_WRITE, 50, fill_value(52));
        send_beat(REQ_STEP, 0, 0);                        // backward miss, forward hit at 50
        send_beat(REQ_READ, 50, 0);
        send_beat(REQ_WRITE, 30, fill_value(32));
        send_beat(REQ_WRITE, 70, fill_value(72));
        send_beat(REQ_RESTART, 0, 0);
        send_beat(REQ_STEP, 0, 0);                        // from 0: hit at 30, not 70
        send_beat(REQ_STEP, 0, 0);
        send_beat(REQ_STEP, 0, 0);                        // done
        send_beat(REQ_STEP, 0, 0);                        // done again, nothing moved
        send_beat(REQ_READ, 31, 0);
    endtask

    // A run of steps with the odd read or restart mixed in.
    task automatic step_run(int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_beat(REQ_READ, $urandom_range(ELEM_COUNT - 1), 0);
            else if (pick < 12)
                send_beat(REQ_RESTART, $urandom_range(ELEM_COUNT - 1), $urandom_range(65535));
            else
                send_beat(REQ_STEP, $urandom_range(ELEM_COUNT - 1), $urandom_range(65535));
        end
    endtask

    // A few small disturbances of a (nearly) sorted array, then enough steps
    // that the sort usually finishes and reports done.
    task automatic perturb_and_sort();
        int spot;
        int near;
        for (int n = $urandom_range(3, 1); n > 0; n--)
        begin
            case ($urandom_range(2))
                0: send_beat(REQ_WRITE, $urandom_range(6), MIN_VALUE);
                1: send_beat(REQ_WRITE, $urandom_range(ELEM_COUNT - 1, ELEM_COUNT - 7), MAX_VALUE);
                default:
                begin
                    spot = $urandom_range(ELEM_COUNT - 4, 3);
                    near = spot + $urandom_range(6) - 3;
                    send_beat(REQ_WRITE, spot, fill_value(near));
                end
            endcase
        end
        step_run($urandom_range(40, 4));
    endtask

    // Unshaped beats: any request, any index, any value.
    task automatic noise_beats();
        for (int n = $urandom_range(6, 1); n > 0; n--)
            send_beat(req_type_t'($urandom_range(3)), $urandom_range(ELEM_COUNT - 1),
                      $urandom_range(65535));
    endtask

    initial
    begin : stimulus
        int random_start;
        int pick;
        rst_n              <= 1'b0;
        request.valid      <= 1'b0;
        request.req_type   <= REQ_WRITE;
        request.elem_index <= '0;
        request.elem_value <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        refill_ramp(1);
        directed_checks();

        // Random part in three idling phases: sender light / receiver heavy,
        // then swapped, then no idling at all.
        random_start = beats_sent;
        while (beats_sent - random_start < RANDOM_BEATS)
        begin
            if (beats_sent - random_start < RANDOM_BEATS / 3)
            begin
                tx_idle_pct = 12;
                rx_idle_pct = 48;
            end
            else if (beats_sent - random_start < 2 * RANDOM_BEATS / 3)
            begin
                tx_idle_pct = 48;
                rx_idle_pct = 12;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            pick = $urandom_range(99);
            if (pick < 6)
                refill_ramp(0);
            else if (pick < 70)
                perturb_and_sort();
            else if (pick < 88)
                noise_beats();
            else
                step_run($urandom_range(120, 40));
        end
        request.valid <= 1'b0;

        // all results in, then let the block settle
        @(posedge clk);
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d writes, %0d reads, %0d restarts and %0d sort steps",
                 write_count, read_count, restart_count, step_count);
        $display("(%0d steps swapped a pair, %0d found the array sorted).",
                 swap_count, done_count);
        if (fail_count == 0 && pending_count == 0)
            $display("stepwise_cocktail_sort_tb passed");
        else
            $display("stepwise_cocktail_sort_tb failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/scs_pkg.sv
sv/scs_in_if.sv
sv/scs_out_if.sv
sv/scs_ctrl.sv
sv/scs_datapath.sv
sv/stepwise_cocktail_sort.sv
sv/scs_checker.sv
tb/sv/stepwise_cocktail_sort_scoreboard.sv
tb/sv/stepwise_cocktail_sort_tb.sv
